>>> rtl/core/pcsg_pkg.sv
// Shared types, opcodes and the circle handle function for the path command
// segment generator. No dependencies.
`timescale 1ns / 1ps

package pcsg_pkg;

   // Command opcodes
   localparam logic [3:0] OP_MOVE      = 4'd0;
   localparam logic [3:0] OP_LINE      = 4'd1;
   localparam logic [3:0] OP_HLINE     = 4'd2;
   localparam logic [3:0] OP_VLINE     = 4'd3;
   localparam logic [3:0] OP_QUAD      = 4'd4;
   localparam logic [3:0] OP_CUBIC     = 4'd5;
   localparam logic [3:0] OP_CLOSE     = 4'd6;
   localparam logic [3:0] OP_RECT      = 4'd7;
   localparam logic [3:0] OP_CIRCLE    = 4'd8;
   localparam logic [3:0] OP_ELLIPSE   = 4'd9;
   localparam logic [3:0] OP_ROUNDRECT = 4'd10;

   // Segment kinds
   localparam logic [1:0] SEG_LINE  = 2'd0;
   localparam logic [1:0] SEG_QUAD  = 2'd1;
   localparam logic [1:0] SEG_CUBIC = 2'd2;

   // 0.551915024494 in unsigned Q0.32, and the half-LSB rounding term
   localparam logic [63:0] HANDLE_Q32   = 64'd2370456980;
   localparam logic [63:0] HANDLE_ROUND = 64'h0000_0000_8000_0000;

   typedef struct packed {
      logic [3:0]         opcode;
      logic               relative;
      logic signed [31:0] p_x;
      logic signed [31:0] p_y;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic [30:0]        r0;
      logic [30:0]        r1;
      logic [30:0]        r2;
      logic [30:0]        r3;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         seg_kind;
      logic signed [31:0] x0;
      logic signed [31:0] y0;
      logic signed [31:0] x1;
      logic signed [31:0] y1;
      logic signed [31:0] x2;
      logic signed [31:0] y2;
      logic signed [31:0] x3;
      logic signed [31:0] y3;
      logic               last;
   } rsp_payload_type;

   // Command staged for segment generation, radius sums and handles resolved
   typedef struct packed {
      logic [3:0]  opcode;
      logic        relative;
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] ax;
      logic [31:0] ay;
      logic [31:0] bx;
      logic [31:0] by;
      logic [31:0] sx_r0;   // px + r0
      logic [31:0] sy_w1;   // py + r1 (r0 for circles)
      logic [31:0] dx;      // px + 2*r0
      logic [31:0] dy;      // py + 2*w1
      logic [31:0] rx;      // px + ax
      logic [31:0] by2;     // py + ay
      logic [31:0] sy_r0;   // py + r0
      logic [31:0] rx_r1;   // rx - r1
      logic [31:0] by2_r2;  // by2 - r2
      logic [31:0] rx_r2;   // rx - r2
      logic [31:0] sx_r3;   // px + r3
      logic [31:0] by2_r3;  // by2 - r3
      logic [31:0] h0;
      logic [31:0] h1;
      logic [31:0] h2;
      logic [31:0] h3;
   } work_type;

   // Bezier handle length for a quarter arc of radius r, rounded half up
   function automatic logic [31:0] handle_of(input logic [30:0] r);
      logic [63:0] prod;
      prod = {33'd0, r} * HANDLE_Q32 + HANDLE_ROUND;
      return prod[63:32];
   endfunction

endpackage

>>> rtl/core/pcsg_channels.sv
// Valid/ready channel interfaces for commands and segments.
// Depends on pcsg_pkg.
`timescale 1ns / 1ps

interface pcsg_req_if;
   import pcsg_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface pcsg_rsp_if;
   import pcsg_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/path_command_segment_generator_unit.sv
// Path command segment generator: top level.
// Depends on pcsg_pkg and the channel interfaces in pcsg_channels.sv.
`timescale 1ns / 1ps

// Usage
// - req_chan carries one path command per beat (move, line, h/v line, quad,
//   cubic, close, rect, circle, ellipse, rounded rect). rsp_chan carries one
//   segment per beat; last marks the final segment of a command.
// - Pipeline: command register -> work register (handle multipliers and
//   radius sums) -> segment sequencer -> output register.
// - Throughput: move and undefined opcodes form no segment; close, lines and
//   curves form one, rect, circle and ellipse four, and rounded rect eight.
//   One segment leaves per cycle while rsp_chan does not stall; the sequencer is
//   the only place segments are formed, so it sets the command rate.
// - Current point and subpath start update when a command leaves the sequencer,
//   as its last segment (if any) enters the output register, so the next command sees them at once.
// - A stall on rsp_chan holds the output register; the sequencer and the
//   command register keep filling behind it, then req_chan.ready drops.
// - Reset (synchronous, active high) empties all stages and clears the
//   current point and subpath start to zero.
// - Opcodes eleven to fifteen are dropped without a segment.
module path_command_segment_generator_unit (
   input logic        clock,
   input logic        reset,
   pcsg_req_if.sink   req_chan,
   pcsg_rsp_if.source rsp_chan
);
   import pcsg_pkg::*;

   // Stage A: command register
   logic            a_valid_ff, a_valid_in;
   req_payload_type a_cmd_ff;

   // Stage B: work register and sequencer
   logic            b_valid_ff, b_valid_in;
   work_type        b_work_ff, b_work_in;
   logic [2:0]      seg_idx_ff, seg_idx_in;

   // Output register
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff;

   // Path state
   logic [31:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [31:0] start_x_ff, start_x_in, start_y_ff, start_y_in;

   logic            req_acc, a_move, out_free, b_free;
   logic            has_seg, b_emit, b_done;
   logic [2:0]      last_idx;
   rsp_payload_type seg;

   function automatic rsp_payload_type mk_seg(
      input logic [1:0] kind,
      input logic [31:0] x0, input logic [31:0] y0,
      input logic [31:0] x1, input logic [31:0] y1,
      input logic [31:0] x2, input logic [31:0] y2,
      input logic [31:0] x3, input logic [31:0] y3);
      rsp_payload_type s;
      s.seg_kind = kind;
      s.x0 = x0; s.y0 = y0; s.x1 = x1; s.y1 = y1;
      s.x2 = x2; s.y2 = y2; s.x3 = x3; s.y3 = y3;
      s.last = 1'b0;
      return s;
   endfunction

   // ---------------- handshake ----------------
   assign out_free         = !out_valid_ff || rsp_chan.ready;
   assign b_emit           = b_valid_ff && has_seg && out_free;
   assign b_done           = b_valid_ff && (!has_seg || (out_free && seg_idx_ff == last_idx));
   assign b_free           = !b_valid_ff || b_done;
   assign a_move           = a_valid_ff && b_free;
   assign req_chan.ready   = !a_valid_ff || b_free;
   assign req_acc          = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

   always_comb begin
      a_valid_in   = req_acc ? 1'b1 : (a_move ? 1'b0 : a_valid_ff);
      b_valid_in   = a_move ? 1'b1 : (b_done ? 1'b0 : b_valid_ff);
      out_valid_in = b_emit ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
      if (b_done) begin
         seg_idx_in = 3'd0;
      end else if (b_emit) begin
         seg_idx_in = seg_idx_ff + 3'd1;
      end else begin
         seg_idx_in = seg_idx_ff;
      end
   end

   // ---------------- stage A -> B: handles and radius sums ----------------
   always_comb begin
      logic [31:0] r0e, r1e, r2e, r3e, w1e, px, py, ax, ay;
      logic [30:0] w1;
      w1  = (a_cmd_ff.opcode == OP_CIRCLE) ? a_cmd_ff.r0 : a_cmd_ff.r1;
      r0e = {1'b0, a_cmd_ff.r0};
      r1e = {1'b0, a_cmd_ff.r1};
      r2e = {1'b0, a_cmd_ff.r2};
      r3e = {1'b0, a_cmd_ff.r3};
      w1e = {1'b0, w1};
      px  = a_cmd_ff.p_x;
      py  = a_cmd_ff.p_y;
      ax  = a_cmd_ff.a_x;
      ay  = a_cmd_ff.a_y;
      b_work_in.opcode   = a_cmd_ff.opcode;
      b_work_in.relative = a_cmd_ff.relative;
      b_work_in.px     = px;
      b_work_in.py     = py;
      b_work_in.ax     = ax;
      b_work_in.ay     = ay;
      b_work_in.bx     = a_cmd_ff.b_x;
      b_work_in.by     = a_cmd_ff.b_y;
      b_work_in.sx_r0  = px + r0e;
      b_work_in.sy_w1  = py + w1e;
      b_work_in.dx     = px + {a_cmd_ff.r0, 1'b0};
      b_work_in.dy     = py + {w1, 1'b0};
      b_work_in.rx     = px + ax;
      b_work_in.by2    = py + ay;
      b_work_in.sy_r0  = py + r0e;
      b_work_in.rx_r1  = px + ax - r1e;
      b_work_in.by2_r2 = py + ay - r2e;
      b_work_in.rx_r2  = px + ax - r2e;
      b_work_in.sx_r3  = px + r3e;
      b_work_in.by2_r3 = py + ay - r3e;
      b_work_in.h0     = handle_of(a_cmd_ff.r0);
      b_work_in.h1     = handle_of(w1);
      b_work_in.h2     = handle_of(a_cmd_ff.r2);
      b_work_in.h3     = handle_of(a_cmd_ff.r3);
   end

   // ---------------- stage B: segment sequencer ----------------
   always_comb begin
      logic [31:0] cx, cy, relx, rely, rax, ray, rbx, rby;
      work_type    w;
      w    = b_work_ff;
      cx   = cur_x_ff;
      cy   = cur_y_ff;
      relx = w.relative ? cx + w.px : w.px;
      rely = w.relative ? cy + w.py : w.py;
      rax  = w.relative ? cx + w.ax : w.ax;
      ray  = w.relative ? cy + w.ay : w.ay;
      rbx  = w.relative ? cx + w.bx : w.bx;
      rby  = w.relative ? cy + w.by : w.by;

      has_seg    = 1'b1;
      last_idx   = 3'd0;
      seg        = mk_seg(SEG_LINE, cx, cy, cx, cy, '0, '0, '0, '0);
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;

      case (w.opcode)
         OP_MOVE: begin
            has_seg    = 1'b0;
            cur_x_in   = relx;
            cur_y_in   = rely;
            start_x_in = relx;
            start_y_in = rely;
         end
         OP_LINE: begin
            seg      = mk_seg(SEG_LINE, cx, cy, relx, rely, '0, '0, '0, '0);
            cur_x_in = relx;
            cur_y_in = rely;
         end
         OP_HLINE: begin
            seg      = mk_seg(SEG_LINE, cx, cy, relx, cy, '0, '0, '0, '0);
            cur_x_in = relx;
         end
         OP_VLINE: begin
            seg      = mk_seg(SEG_LINE, cx, cy, cx, rely, '0, '0, '0, '0);
            cur_y_in = rely;
         end
         OP_QUAD: begin
            seg      = mk_seg(SEG_QUAD, cx, cy, w.ax, w.ay, w.px, w.py, '0, '0);
            cur_x_in = w.px;
            cur_y_in = w.py;
         end
         OP_CUBIC: begin
            seg      = mk_seg(SEG_CUBIC, cx, cy, rax, ray, rbx, rby, relx, rely);
            cur_x_in = relx;
            cur_y_in = rely;
         end
         OP_CLOSE: begin
            seg      = mk_seg(SEG_LINE, cx, cy, start_x_ff, start_y_ff, '0, '0, '0, '0);
            cur_x_in = start_x_ff;
            cur_y_in = start_y_ff;
         end
         OP_RECT: begin
            last_idx = 3'd3;
            cur_x_in = w.px;
            cur_y_in = w.py;
            case (seg_idx_ff[1:0])
               2'd0:    seg = mk_seg(SEG_LINE, w.px, w.py, w.px, w.by2, '0, '0, '0, '0);
               2'd1:    seg = mk_seg(SEG_LINE, w.px, w.by2, w.rx, w.by2, '0, '0, '0, '0);
               2'd2:    seg = mk_seg(SEG_LINE, w.rx, w.by2, w.rx, w.py, '0, '0, '0, '0);
               default: seg = mk_seg(SEG_LINE, w.rx, w.py, w.px, w.py, '0, '0, '0, '0);
            endcase
         end
         OP_CIRCLE, OP_ELLIPSE: begin
            last_idx = 3'd3;
            cur_x_in = w.px;
            cur_y_in = w.sy_w1;
            // quarter arcs clockwise from the top middle of the box
            case (seg_idx_ff[1:0])
               2'd0: seg = mk_seg(SEG_CUBIC, w.sx_r0, w.py, w.sx_r0 + w.h0, w.py,
                                  w.dx, w.sy_w1 - w.h1, w.dx, w.sy_w1);
               2'd1: seg = mk_seg(SEG_CUBIC, w.dx, w.sy_w1, w.dx, w.sy_w1 + w.h1,
                                  w.sx_r0 + w.h0, w.dy, w.sx_r0, w.dy);
               2'd2: seg = mk_seg(SEG_CUBIC, w.sx_r0, w.dy, w.sx_r0 - w.h0, w.dy,
                                  w.px, w.sy_w1 + w.h1, w.px, w.sy_w1);
               default: seg = mk_seg(SEG_CUBIC, w.px, w.sy_w1, w.px, w.sy_w1 - w.h1,
                                     w.sx_r0 - w.h0, w.py, w.sx_r0, w.py);
            endcase
         end
         OP_ROUNDRECT: begin
            last_idx = 3'd7;
            cur_x_in = w.sx_r0;
            cur_y_in = w.py;
            // edges alternate with corners: top, top-right, right, ...
            case (seg_idx_ff)
               3'd0: seg = mk_seg(SEG_LINE, w.sx_r0, w.py, w.rx_r1, w.py, '0, '0, '0, '0);
               3'd1: seg = mk_seg(SEG_CUBIC, w.rx_r1, w.py, w.rx_r1 + w.h1, w.py,
                                  w.rx, w.sy_w1 - w.h1, w.rx, w.sy_w1);
               3'd2: seg = mk_seg(SEG_LINE, w.rx, w.sy_w1, w.rx, w.by2_r2, '0, '0, '0, '0);
               3'd3: seg = mk_seg(SEG_CUBIC, w.rx, w.by2_r2, w.rx, w.by2_r2 + w.h2,
                                  w.rx_r2 + w.h2, w.by2, w.rx_r2, w.by2);
               3'd4: seg = mk_seg(SEG_LINE, w.rx_r2, w.by2, w.sx_r3, w.by2, '0, '0, '0, '0);
               3'd5: seg = mk_seg(SEG_CUBIC, w.sx_r3, w.by2, w.sx_r3 - w.h3, w.by2,
                                  w.px, w.by2_r3 + w.h3, w.px, w.by2_r3);
               3'd6: seg = mk_seg(SEG_LINE, w.px, w.by2_r3, w.px, w.sy_r0, '0, '0, '0, '0);
               default: seg = mk_seg(SEG_CUBIC, w.px, w.sy_r0, w.px, w.sy_r0 - w.h0,
                                     w.sx_r0 - w.h0, w.py, w.sx_r0, w.py);
            endcase
         end
         default: begin
            has_seg = 1'b0;   // undefined opcode: dropped
         end
      endcase
      seg.last = (seg_idx_ff == last_idx);
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         seg_idx_ff   <= 3'd0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
         seg_idx_ff   <= seg_idx_in;
         if (b_done) begin
            cur_x_ff   <= cur_x_in;
            cur_y_ff   <= cur_y_in;
            start_x_ff <= start_x_in;
            start_y_ff <= start_y_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         a_cmd_ff <= req_chan.payload;
      end
      if (a_move) begin
         b_work_ff <= b_work_in;
      end
      if (b_emit) begin
         out_ff <= seg;
      end
   end

endmodule
